// File: src/deq_pkg.sv
// shared types and constants for the double-ended queue
package deq_pkg;

   localparam int DEPTH_DEFAULT      = 256;
   localparam int WORD_WIDTH_DEFAULT = 32;
   localparam int VALUE_WIDTH        = 32;
   localparam int RESULT_WIDTH       = 32;

   typedef enum logic [2:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_PEEK_FRONT = 3'd4,
      MODE_PEEK_BACK  = 3'd5,
      MODE_CLEAR      = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]             mode;
      logic [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [RESULT_WIDTH-1:0] word;
   } rsp_type;

   // response control handed from the pointer logic to the output stage
   typedef struct packed {
      logic       valid;
      status_type status;
      logic       word_sel;
   } rsp_ctl_type;

endpackage

// File: src/deq_ring.sv
// single-port ring memory with registered read data
module deq_ring import deq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT,
   parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic                  rd_en,
   input  logic [AW-1:0]         addr,
   input  logic [WORD_WIDTH-1:0] wr_data,
   output logic [WORD_WIDTH-1:0] rd_data
);

   logic [WORD_WIDTH-1:0] mem [DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/deq_ctrl.sv
// front pointer, occupancy and request decode for the double-ended queue
module deq_ctrl import deq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT,
   parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  req_type               req,
   output logic                  mem_we,
   output logic                  mem_re,
   output logic [AW-1:0]         mem_addr,
   output logic [WORD_WIDTH-1:0] mem_wdata,
   output rsp_ctl_type           rsp_ctl
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [AW-1:0] LAST   = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_N = CW'(DEPTH);
   localparam logic [SW-1:0] WRAP_N = SW'(DEPTH);

   logic [AW-1:0]   front_ff, front_in;
   logic [CW-1:0]   occ_ff, occ_in;
   rsp_ctl_type     rsp_ctl_ff, rsp_ctl_in;

   logic            empty, full;
   logic [AW-1:0]   front_dec, front_inc, tail_idx, back_idx;
   logic [SW-1:0]   tail_sum, back_sum, tail_wrap, back_wrap;
   logic [63:0]     value_wide;

   always_comb begin
      empty      = (occ_ff == '0);
      full       = (occ_ff == FULL_N);
      front_dec  = (front_ff == '0) ? LAST : front_ff - AW'(1);
      front_inc  = (front_ff == LAST) ? '0 : front_ff + AW'(1);
      // front + occupancy stays below twice the depth: one compare-subtract wraps it
      tail_sum   = SW'(front_ff) + SW'(occ_ff);
      tail_wrap  = (tail_sum >= WRAP_N) ? tail_sum - WRAP_N : tail_sum;
      tail_idx   = tail_wrap[AW-1:0];
      back_sum   = tail_sum - SW'(1);
      back_wrap  = (back_sum >= WRAP_N) ? back_sum - WRAP_N : back_sum;
      back_idx   = back_wrap[AW-1:0];
      value_wide = 64'(req.value);
   end

   always_comb begin
      front_in         = front_ff;
      occ_in           = occ_ff;
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      mem_addr         = front_ff;
      mem_wdata        = value_wide[WORD_WIDTH-1:0];
      rsp_ctl_in       = '0;
      rsp_ctl_in.valid = accept;
      rsp_ctl_in.status = STATUS_OK;
      if (accept) begin
         unique case (req.mode) inside
            MODE_PUSH_FRONT: begin
               if (full) begin
                  rsp_ctl_in.status = STATUS_FULL;
               end else begin
                  mem_we   = 1'b1;
                  mem_addr = front_dec;
                  front_in = front_dec;
                  occ_in   = occ_ff + CW'(1);
               end
            end
            MODE_PUSH_BACK: begin
               if (full) begin
                  rsp_ctl_in.status = STATUS_FULL;
               end else begin
                  mem_we   = 1'b1;
                  mem_addr = tail_idx;
                  occ_in   = occ_ff + CW'(1);
               end
            end
            MODE_POP_FRONT, MODE_PEEK_FRONT: begin
               if (empty) begin
                  rsp_ctl_in.status = STATUS_EMPTY;
               end else begin
                  mem_re              = 1'b1;
                  mem_addr            = front_ff;
                  rsp_ctl_in.word_sel = 1'b1;
                  if (req.mode == MODE_POP_FRONT) begin
                     front_in = front_inc;
                     occ_in   = occ_ff - CW'(1);
                  end
               end
            end
            MODE_POP_BACK, MODE_PEEK_BACK: begin
               if (empty) begin
                  rsp_ctl_in.status = STATUS_EMPTY;
               end else begin
                  mem_re              = 1'b1;
                  mem_addr            = back_idx;
                  rsp_ctl_in.word_sel = 1'b1;
                  if (req.mode == MODE_POP_BACK) begin
                     occ_in = occ_ff - CW'(1);
                  end
               end
            end
            MODE_CLEAR: begin
               front_in = '0;
               occ_in   = '0;
            end
            default: begin
               // unused mode: answer ok, no change
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff   <= '0;
         occ_ff     <= '0;
         rsp_ctl_ff <= '0;
      end else begin
         front_ff   <= front_in;
         occ_ff     <= occ_in;
         rsp_ctl_ff <= rsp_ctl_in;
      end
   end

   assign rsp_ctl = rsp_ctl_ff;

endmodule

// File: src/double_ended_queue_top.sv
// top level of the double-ended queue
//
//   channel   ports                        direction  handshake
//   request   start, busy, req_data        in         transfer when start and not busy
//   response  rsp_valid, rsp_data          out        one-cycle strobe, cannot be held off
//
// one request per cycle; the response appears on the cycle after the request transfer
// the single-port ring memory does at most one read or one write per request, read data
// registered, so a pop or peek answers in the cycle after its address goes out
// a write is in the memory by the next edge, so a read right after a push sees it
// synchronous active-high reset clears the pointer, occupancy and response strobe;
// ring contents are not cleared and no clearing pass runs
// busy stays low: the response side has no stall and the ring never waits
module double_ended_queue_top import deq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                  accept;
   logic                  mem_we;
   logic                  mem_re;
   logic [AW-1:0]         mem_addr;
   logic [WORD_WIDTH-1:0] mem_wdata;
   logic [WORD_WIDTH-1:0] mem_rdata;
   rsp_ctl_type           rsp_ctl;
   logic [63:0]           rdata_wide;

   // every request is taken as it comes and nothing stalls, so the block never refuses one
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // pointer and occupancy logic, drives the ring port
   deq_ctrl #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .AW         (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .rsp_ctl   (rsp_ctl)
   );

   // ring storage
   deq_ring #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .AW         (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   // word is the read data only for a pop or peek that found an entry, else zero
   assign rdata_wide      = 64'(mem_rdata);
   assign rsp_valid       = rsp_ctl.valid;
   assign rsp_data.status = rsp_ctl.status;
   assign rsp_data.word   = rsp_ctl.word_sel ? rdata_wide[RESULT_WIDTH-1:0] : '0;

endmodule

// File: dv/double_ended_queue_top_tb.sv
// self-checking testbench for the double-ended queue top level
`timescale 1ns / 1ps

module double_ended_queue_top_tb;
   import deq_pkg::*;

   // the one code that the mode field leaves unassigned; the block answers ok and moves nothing
   localparam logic [2:0] MODE_UNUSED = 3'd7;
   localparam int RING_DEPTH = DEPTH_DEFAULT;
   // cycles with no transfer on either side before the run is called hung
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 800;

   // shadow copy of the ring: applies each accepted request and keeps the answers it owes
   class deque_mirror;
      logic [WORD_WIDTH_DEFAULT-1:0] ring [RING_DEPTH];
      logic [7:0] head = '0;
      logic [8:0] fill = '0;
      rsp_type due_responses [$];
      int mismatches = 0;

      function void apply_request(req_type req);
         rsp_type ans;
         logic [7:0] tail;
         ans.status = STATUS_OK;
         ans.word = '0;
         tail = head + fill[7:0] - 8'd1;
         case (req.mode) inside
            MODE_PUSH_FRONT: begin
               if (fill == RING_DEPTH) begin
                  ans.status = STATUS_FULL;
               end else begin
                  head = head - 8'd1;
                  ring[head] = req.value;
                  fill = fill + 9'd1;
               end
            end
            MODE_PUSH_BACK: begin
               if (fill == RING_DEPTH) begin
                  ans.status = STATUS_FULL;
               end else begin
                  ring[head + fill[7:0]] = req.value;
                  fill = fill + 9'd1;
               end
            end
            MODE_POP_FRONT, MODE_PEEK_FRONT: begin
               if (fill == 0) begin
                  ans.status = STATUS_EMPTY;
               end else begin
                  ans.word = ring[head];
                  if (req.mode == MODE_POP_FRONT) begin
                     head = head + 8'd1;
                     fill = fill - 9'd1;
                  end
               end
            end
            MODE_POP_BACK, MODE_PEEK_BACK: begin
               if (fill == 0) begin
                  ans.status = STATUS_EMPTY;
               end else begin
                  ans.word = ring[tail];
                  if (req.mode == MODE_POP_BACK) fill = fill - 9'd1;
               end
            end
            MODE_CLEAR: begin
               head = '0;
               fill = '0;
            end
            default: ;
         endcase
         due_responses.push_back(ans);
      endfunction

      function void flag(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%s: expected status %0d word %h, got status %0d word %h",
                     what, want.status, want.word, got.status, got.word);
      endfunction

      function void match_response(rsp_type got);
         rsp_type want;
         if (due_responses.size() == 0) begin
            want = '0;
            flag("unexpected response", want, got);
         end else begin
            want = due_responses.pop_front();
            if (got.status !== want.status || got.word !== want.word)
               flag("response mismatch", want, got);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   deque_mirror mirror;
   int quiet_cycles = 0;

   double_ended_queue_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one process watches both channels at every edge; the response is checked before
   // the request of the same edge is noted, since a response answers the previous transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) mirror.match_response(rsp_data);
         if (start && !busy) mirror.apply_request(req_data);
         if (rsp_valid || (start && !busy)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         // watchdog: nothing moved for far longer than any legal gap
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // present one request and hold it until the block takes it;
   // optional random idle cycles go in front of it
   task automatic send_request(input logic [2:0] op, input logic [31:0] data,
                               input bit may_idle);
      if (may_idle) begin
         while ($urandom_range(99) < 16) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_data.mode <= op;
      req_data.value <= data;
      @(posedge clock);
      // busy is sampled as it stood before the edge
      while (busy) @(posedge clock);
   endtask

   // data words lean toward the extremes now and then
   function automatic logic [31:0] pick_value();
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) return 32'h0000_0000;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // fill: mostly pushes so the ring runs into full
   function automatic logic [2:0] fill_mode();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 47) return MODE_PUSH_FRONT;
      if (r < 94) return MODE_PUSH_BACK;
      if (r < 96) return MODE_PEEK_FRONT;
      if (r < 98) return MODE_PEEK_BACK;
      return ($urandom_range(1) != 0) ? MODE_POP_FRONT : MODE_POP_BACK;
   endfunction

   // drain: mostly pops so the ring runs down to empty and past it
   function automatic logic [2:0] drain_mode();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45) return MODE_POP_FRONT;
      if (r < 90) return MODE_POP_BACK;
      if (r < 93) return MODE_PEEK_FRONT;
      if (r < 96) return MODE_PEEK_BACK;
      return ($urandom_range(1) != 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
   endfunction

   // mixed: every code, with clear and the unused code kept rare
   function automatic logic [2:0] mixed_mode();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 3) return MODE_CLEAR;
      if (r < 5) return MODE_UNUSED;
      return 3'($urandom_range(5));
   endfunction

   initial begin
      logic [2:0] op;
      mirror = new();

      // reset held high at the start, then released on an edge
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reads on an empty queue leave everything as it was
      send_request(MODE_POP_FRONT, 32'hFFFF_FFFF, 1'b1);
      send_request(MODE_POP_BACK, 32'h0000_0000, 1'b1);
      send_request(MODE_PEEK_FRONT, 32'h1234_5678, 1'b1);
      send_request(MODE_PEEK_BACK, 32'h8765_4321, 1'b1);
      // extreme words at both ends, then read them back from both ends
      send_request(MODE_PUSH_FRONT, 32'h0000_0000, 1'b1);
      send_request(MODE_PUSH_BACK, 32'hFFFF_FFFF, 1'b1);
      send_request(MODE_PUSH_FRONT, 32'hA5A5_A5A5, 1'b1);
      send_request(MODE_PUSH_BACK, 32'h5A5A_5A5A, 1'b1);
      send_request(MODE_PEEK_FRONT, 32'h0, 1'b1);
      send_request(MODE_PEEK_BACK, 32'h0, 1'b1);
      send_request(MODE_POP_FRONT, 32'h0, 1'b1);
      send_request(MODE_POP_BACK, 32'h0, 1'b1);
      send_request(MODE_PEEK_FRONT, 32'h0, 1'b1);
      send_request(MODE_PEEK_BACK, 32'h0, 1'b1);
      // unused code answers ok and moves nothing
      send_request(MODE_UNUSED, 32'hFFFF_FFFF, 1'b1);
      send_request(MODE_PEEK_BACK, 32'h0, 1'b1);
      // clear with words held, then the queue reads as empty
      send_request(MODE_CLEAR, 32'hFFFF_FFFF, 1'b1);
      send_request(MODE_PEEK_BACK, 32'h0, 1'b1);
      send_request(MODE_POP_FRONT, 32'h0, 1'b1);
      // push right after clear, read back at once (no idle, back to back)
      send_request(MODE_PUSH_BACK, 32'hDEAD_BEEF, 1'b0);
      send_request(MODE_POP_BACK, 32'h0, 1'b0);
      send_request(MODE_CLEAR, 32'h0, 1'b0);

      // random: fill past full, drain past empty, then a mixed tail;
      // a long stretch in the middle runs without idle cycles
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i < 300) begin
            op = fill_mode();
         end else if (i < 600) begin
            op = drain_mode();
         end else begin
            op = mixed_mode();
         end
         send_request(op, pick_value(), !(i >= 350 && i < 500));
      end
      start <= 1'b0;

      // let the last responses come back; the watchdog covers a hang
      while (mirror.due_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (mirror.mismatches == 0 && mirror.due_responses.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
src/deq_pkg.sv
src/deq_ring.sv
src/deq_ctrl.sv
src/double_ended_queue_top.sv
dv/double_ended_queue_top_tb.sv
